/* design/c8alu_pkg.sv */
package c8alu_pkg;

    localparam logic [5:0] OP_ADD   = 6'd0;
    localparam logic [5:0] OP_ADC   = 6'd1;
    localparam logic [5:0] OP_SUB   = 6'd2;
    localparam logic [5:0] OP_SBC   = 6'd3;
    localparam logic [5:0] OP_AND   = 6'd4;
    localparam logic [5:0] OP_OR    = 6'd5;
    localparam logic [5:0] OP_XOR   = 6'd6;
    localparam logic [5:0] OP_CP    = 6'd7;
    localparam logic [5:0] OP_INC8  = 6'd8;
    localparam logic [5:0] OP_DEC8  = 6'd9;
    localparam logic [5:0] OP_INC16 = 6'd10;
    localparam logic [5:0] OP_DEC16 = 6'd11;
    localparam logic [5:0] OP_CPL   = 6'd12;
    localparam logic [5:0] OP_BIT   = 6'd13;
    localparam logic [5:0] OP_RES   = 6'd14;
    localparam logic [5:0] OP_SET   = 6'd15;
    localparam logic [5:0] OP_RLCA  = 6'd16;
    localparam logic [5:0] OP_RLA   = 6'd17;
    localparam logic [5:0] OP_RRCA  = 6'd18;
    localparam logic [5:0] OP_RRA   = 6'd19;
    localparam logic [5:0] OP_RLC   = 6'd20;
    localparam logic [5:0] OP_RL    = 6'd21;
    localparam logic [5:0] OP_RRC   = 6'd22;
    localparam logic [5:0] OP_RR    = 6'd23;
    localparam logic [5:0] OP_SLA   = 6'd24;
    localparam logic [5:0] OP_SRA   = 6'd25;
    localparam logic [5:0] OP_SRL   = 6'd26;
    localparam logic [5:0] OP_SWAP  = 6'd27;
    localparam logic [5:0] OP_CCF   = 6'd28;
    localparam logic [5:0] OP_SCF   = 6'd29;
    localparam logic [5:0] OP_ADDHL = 6'd30;
    localparam logic [5:0] OP_ADDSP = 6'd31;
    localparam logic [5:0] OP_DAA   = 6'd32;
    localparam logic [5:0] OP_DI    = 6'd33;
    localparam logic [5:0] OP_EI    = 6'd34;

    // Operation classes assigned by the front end.
    localparam logic [2:0] CLS_ARITH = 3'd0;
    localparam logic [2:0] CLS_LOGIC = 3'd1;
    localparam logic [2:0] CLS_UNARY = 3'd2;
    localparam logic [2:0] CLS_SHIFT = 3'd3;
    localparam logic [2:0] CLS_WORD  = 3'd4;
    localparam logic [2:0] CLS_MISC  = 3'd5;
    localparam logic [2:0] CLS_NOP   = 3'd6;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [5:0]  op;
        logic [7:0]  operand_byte;
        logic        target_is_acc;
        logic [2:0]  bit_index;
        logic [15:0] word_left;
        logic [15:0] word_right;
        logic [7:0]  offset;
    } item_t;

    typedef struct packed {
        logic [2:0] cls;
        item_t      item;
    } decoded_t;

    typedef struct packed {
        logic [7:0]  result_byte;
        logic [15:0] result_word;
        logic [7:0]  acc_out;
        logic        zero_flag;
        logic        subtract_flag;
        logic        half_flag;
        logic        carry_flag;
        logic        irq_enabled;
    } result_t;

endpackage

/* design/c8alu_if.sv */
interface c8alu_in_if;
    logic        valid;
    logic        ready;
    logic [5:0]  op;
    logic [7:0]  operand_byte;
    logic        target_is_acc;
    logic [2:0]  bit_index;
    logic [15:0] word_left;
    logic [15:0] word_right;
    logic signed [7:0] offset;

    modport source (output valid, op, operand_byte, target_is_acc, bit_index,
                    word_left, word_right, offset, input ready);
    modport sink (input valid, op, operand_byte, target_is_acc, bit_index,
                  word_left, word_right, offset, output ready);
endinterface

interface c8alu_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  result_byte;
    logic [15:0] result_word;
    logic [7:0]  acc_out;
    logic        zero_flag;
    logic        subtract_flag;
    logic        half_flag;
    logic        carry_flag;
    logic        irq_enabled;

    modport source (output valid, result_byte, result_word, acc_out, zero_flag,
                    subtract_flag, half_flag, carry_flag, irq_enabled, input ready);
    modport sink (input valid, result_byte, result_word, acc_out, zero_flag,
                  subtract_flag, half_flag, carry_flag, irq_enabled, output ready);
endinterface

/* design/cpu8_alu_with_flags_core.sv */
// 8-bit CPU ALU with accumulator, Z/N/H/C flags and interrupt master enable.
// Input channel in_ch carries one operation word (op, operands, bit index,
// 16-bit operands and signed offset); output channel out_ch carries one
// result word per operation: result byte, result word, accumulator and the
// flags after the operation.
// The front stage registers and classifies each word, a two-entry queue
// decouples it from the back stage, and the back stage executes against the
// held accumulator and flags and registers the result.
// Each accepted word passes the front register, the queue and the result
// register before its result is valid. Throughput is one word per cycle while the
// receiver does not stall; the back stage reads and writes the accumulator and flags for each word.
// Reset clears the accumulator, flags, interrupt enable and all valid bits.
// When the receiver holds ready low, the result register holds, then the
// queue fills, then the front register, and in_ch.ready drops.
module cpu8_alu_with_flags_core (
    input  logic        clk,
    input  logic        rst_n,
    c8alu_in_if.sink    in_ch,
    c8alu_out_if.source out_ch
);

    c8alu_pkg::decoded_t f_word, q_word;
    logic f_valid, f_ready, q_valid, q_ready;

    c8alu_front u_front (
        .clk, .rst_n, .in_ch,
        .dec_word(f_word), .dec_valid(f_valid), .dec_ready(f_ready)
    );

    c8alu_queue u_queue (
        .clk, .rst_n,
        .wr_word(f_word), .wr_valid(f_valid), .wr_ready(f_ready),
        .rd_word(q_word), .rd_valid(q_valid), .rd_ready(q_ready)
    );

    c8alu_back u_back (
        .clk, .rst_n,
        .dec_word(q_word), .dec_valid(q_valid), .dec_ready(q_ready), .out_ch
    );

endmodule

/* design/c8alu_front.sv */
module c8alu_front (
    input  logic                 clk,
    input  logic                 rst_n,
    c8alu_in_if.sink             in_ch,
    output c8alu_pkg::decoded_t  dec_word,
    output logic                 dec_valid,
    input  logic                 dec_ready
);

    logic [2:0] cls;

    always_comb
    begin
        if (in_ch.op <= c8alu_pkg::OP_CP)
        begin
            if (in_ch.op == c8alu_pkg::OP_AND || in_ch.op == c8alu_pkg::OP_OR ||
                in_ch.op == c8alu_pkg::OP_XOR)
                cls = c8alu_pkg::CLS_LOGIC;
            else
                cls = c8alu_pkg::CLS_ARITH;
        end
        else if (in_ch.op == c8alu_pkg::OP_INC16 || in_ch.op == c8alu_pkg::OP_DEC16 ||
                 in_ch.op == c8alu_pkg::OP_ADDHL || in_ch.op == c8alu_pkg::OP_ADDSP)
            cls = c8alu_pkg::CLS_WORD;
        else if (in_ch.op >= c8alu_pkg::OP_RLCA && in_ch.op <= c8alu_pkg::OP_SWAP)
            cls = c8alu_pkg::CLS_SHIFT;
        else if (in_ch.op >= c8alu_pkg::OP_INC8 && in_ch.op <= c8alu_pkg::OP_SET)
            cls = c8alu_pkg::CLS_UNARY;
        else if (in_ch.op >= c8alu_pkg::OP_CCF && in_ch.op <= c8alu_pkg::OP_EI)
            cls = c8alu_pkg::CLS_MISC;
        else
            cls = c8alu_pkg::CLS_NOP;
    end

    // Forward queue register; one decoded word held at a time.
    logic                 valid_reg;
    c8alu_pkg::decoded_t  word_reg;

    assign in_ch.ready = !valid_reg || dec_ready;
    assign dec_valid   = valid_reg;
    assign dec_word    = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ch.ready)
            valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            word_reg.cls                <= cls;
            word_reg.item.op            <= in_ch.op;
            word_reg.item.operand_byte  <= in_ch.operand_byte;
            word_reg.item.target_is_acc <= in_ch.target_is_acc;
            word_reg.item.bit_index     <= in_ch.bit_index;
            word_reg.item.word_left     <= in_ch.word_left;
            word_reg.item.word_right    <= in_ch.word_right;
            word_reg.item.offset        <= in_ch.offset;
        end
    end

endmodule

/* design/c8alu_queue.sv */
module c8alu_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  c8alu_pkg::decoded_t  wr_word,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    output c8alu_pkg::decoded_t  rd_word,
    output logic                 rd_valid,
    input  logic                 rd_ready
);

    c8alu_pkg::decoded_t mem_reg [c8alu_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign wr_ready = count_reg != 2'(c8alu_pkg::QUEUE_DEPTH);
    assign rd_valid = count_reg != 2'd0;
    assign rd_word  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> !push)
        else $error("queue written while full");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not follow a push");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd1 |-> wr_ptr_reg != rd_ptr_reg)
        else $error("queue pointers out of step");

endmodule

/* design/c8alu_back.sv */
module c8alu_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  c8alu_pkg::decoded_t  dec_word,
    input  logic                 dec_valid,
    output logic                 dec_ready,
    c8alu_out_if.source          out_ch
);

    logic [7:0] acc_reg;
    logic       z_reg, n_reg, h_reg, c_reg, ime_reg;
    logic       out_valid_reg;
    c8alu_pkg::result_t res_reg, res_next;

    logic [7:0] a, v, a_n, rb, sh_in, sh_out, mask;
    logic [15:0] rw, wl, wr;
    logic z, n, h, c, ime, cin, sh_co;
    logic [8:0] s9;
    logic [4:0] s5;
    logic [16:0] s17;
    logic [12:0] s13;
    logic [2:0] kind;
    logic [5:0] op;
    logic fire;

    assign dec_ready = !out_valid_reg || out_ch.ready;
    assign fire      = dec_valid && dec_ready;

    assign op   = dec_word.item.op;
    assign v    = dec_word.item.operand_byte;
    assign wl   = dec_word.item.word_left;
    assign wr   = dec_word.item.word_right;
    assign mask = 8'(1) << dec_word.item.bit_index;
    assign sh_in = (dec_word.cls == c8alu_pkg::CLS_SHIFT && op < c8alu_pkg::OP_RLC) ?
                   acc_reg : v;
    assign kind  = (op < c8alu_pkg::OP_RLC) ? 3'(op - c8alu_pkg::OP_RLCA)
                                            : 3'(op - c8alu_pkg::OP_RLC);

    always_comb
    begin
        unique case (kind)
            3'd0: begin sh_co = sh_in[7]; sh_out = {sh_in[6:0], sh_in[7]}; end
            3'd1: begin sh_co = sh_in[7]; sh_out = {sh_in[6:0], c_reg}; end
            3'd2: begin sh_co = sh_in[0]; sh_out = {sh_in[0], sh_in[7:1]}; end
            3'd3: begin sh_co = sh_in[0]; sh_out = {c_reg, sh_in[7:1]}; end
            3'd4: begin sh_co = sh_in[7]; sh_out = {sh_in[6:0], 1'b0}; end
            3'd5: begin sh_co = sh_in[0]; sh_out = {sh_in[7], sh_in[7:1]}; end
            3'd6: begin sh_co = sh_in[0]; sh_out = {1'b0, sh_in[7:1]}; end
            default: begin sh_co = 1'b0; sh_out = {sh_in[3:0], sh_in[7:4]}; end
        endcase
    end

    always_comb
    begin
        a = acc_reg; z = z_reg; n = n_reg; h = h_reg; c = c_reg; ime = ime_reg;
        rb = 8'd0; rw = 16'd0; a_n = 8'd0; s9 = 9'd0; s5 = 5'd0; s17 = 17'd0;
        s13 = 13'd0;
        cin = (op == c8alu_pkg::OP_ADC || op == c8alu_pkg::OP_SBC) ? c_reg : 1'b0;
        unique case (op)
            c8alu_pkg::OP_ADD, c8alu_pkg::OP_ADC:
            begin
                s9 = {1'b0, acc_reg} + {1'b0, v} + 9'(cin);
                s5 = {1'b0, acc_reg[3:0]} + {1'b0, v[3:0]} + 5'(cin);
                h = s5[4]; c = s9[8]; a = s9[7:0]; z = a == 8'd0; n = 1'b0; rb = a;
            end
            c8alu_pkg::OP_SUB, c8alu_pkg::OP_SBC, c8alu_pkg::OP_CP:
            begin
                s9 = {1'b0, acc_reg} - {1'b0, v} - 9'(cin);
                s5 = {1'b0, acc_reg[3:0]} - {1'b0, v[3:0]} - 5'(cin);
                h = s5[4]; c = s9[8]; z = s9[7:0] == 8'd0; n = 1'b1; rb = s9[7:0];
                if (op != c8alu_pkg::OP_CP)
                    a = s9[7:0];
            end
            c8alu_pkg::OP_AND:
            begin
                a = acc_reg & v; z = a == 8'd0; n = 1'b0; h = 1'b1; c = 1'b0; rb = a;
            end
            c8alu_pkg::OP_OR:
            begin
                a = acc_reg | v; z = a == 8'd0; n = 1'b0; h = 1'b0; c = 1'b0; rb = a;
            end
            c8alu_pkg::OP_XOR:
            begin
                a = acc_reg ^ v; z = a == 8'd0; n = 1'b0; h = 1'b0; c = 1'b0; rb = a;
            end
            c8alu_pkg::OP_INC8:
            begin
                rb = v + 8'd1; z = rb == 8'd0; n = 1'b0; h = v[3:0] == 4'hF;
                if (dec_word.item.target_is_acc) a = rb;
            end
            c8alu_pkg::OP_DEC8:
            begin
                rb = v - 8'd1; z = rb == 8'd0; n = 1'b1; h = v[3:0] == 4'h0;
                if (dec_word.item.target_is_acc) a = rb;
            end
            c8alu_pkg::OP_INC16: rw = wl + 16'd1;
            c8alu_pkg::OP_DEC16: rw = wl - 16'd1;
            c8alu_pkg::OP_CPL:
            begin
                a = ~acc_reg; n = 1'b1; h = 1'b1; rb = a;
            end
            c8alu_pkg::OP_BIT:
            begin
                z = (v & mask) == 8'd0; n = 1'b0; h = 1'b1; rb = v;
            end
            c8alu_pkg::OP_RES:
            begin
                rb = v & ~mask;
                if (dec_word.item.target_is_acc) a = rb;
            end
            c8alu_pkg::OP_SET:
            begin
                rb = v | mask;
                if (dec_word.item.target_is_acc) a = rb;
            end
            c8alu_pkg::OP_RLCA, c8alu_pkg::OP_RLA, c8alu_pkg::OP_RRCA, c8alu_pkg::OP_RRA:
            begin
                a = sh_out; c = sh_co; z = 1'b0; n = 1'b0; h = 1'b0; rb = a;
            end
            c8alu_pkg::OP_RLC, c8alu_pkg::OP_RL, c8alu_pkg::OP_RRC, c8alu_pkg::OP_RR,
            c8alu_pkg::OP_SLA, c8alu_pkg::OP_SRA, c8alu_pkg::OP_SRL, c8alu_pkg::OP_SWAP:
            begin
                rb = sh_out; c = sh_co; z = rb == 8'd0; n = 1'b0; h = 1'b0;
                if (dec_word.item.target_is_acc) a = rb;
            end
            c8alu_pkg::OP_CCF:
            begin
                c = !c_reg; n = 1'b0; h = 1'b0;
            end
            c8alu_pkg::OP_SCF:
            begin
                c = 1'b1; n = 1'b0; h = 1'b0;
            end
            c8alu_pkg::OP_ADDHL:
            begin
                s17 = {1'b0, wl} + {1'b0, wr};
                s13 = {1'b0, wl[11:0]} + {1'b0, wr[11:0]};
                h = s13[12]; c = s17[16]; n = 1'b0; rw = s17[15:0];
            end
            c8alu_pkg::OP_ADDSP:
            begin
                rw = wl + {{8{dec_word.item.offset[7]}}, dec_word.item.offset};
                s5 = {1'b0, wl[3:0]} + {1'b0, dec_word.item.offset[3:0]};
                s9 = {1'b0, wl[7:0]} + {1'b0, dec_word.item.offset};
                h = s5[4]; c = s9[8]; z = 1'b0; n = 1'b0;
            end
            c8alu_pkg::OP_DAA:
            begin
                a_n = acc_reg;
                if (!n_reg)
                begin
                    if (c_reg || acc_reg > 8'h99)
                    begin
                        a_n = a_n + 8'h60; c = 1'b1;
                    end
                    if (h_reg || a_n[3:0] > 4'h9)
                        a_n = a_n + 8'h06;
                end
                else
                begin
                    if (c_reg) a_n = a_n - 8'h60;
                    if (h_reg) a_n = a_n - 8'h06;
                end
                a = a_n; z = a == 8'd0; h = 1'b0; rb = a;
            end
            c8alu_pkg::OP_DI: ime = 1'b0;
            c8alu_pkg::OP_EI: ime = 1'b1;
            default: ;
        endcase
        res_next = '{result_byte: rb, result_word: rw, acc_out: a, zero_flag: z,
                     subtract_flag: n, half_flag: h, carry_flag: c, irq_enabled: ime};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 8'd0; z_reg <= 1'b0; n_reg <= 1'b0; h_reg <= 1'b0;
            c_reg <= 1'b0; ime_reg <= 1'b0; out_valid_reg <= 1'b0;
        end
        else
        begin
            if (dec_ready)
                out_valid_reg <= dec_valid;
            if (fire)
            begin
                acc_reg <= res_next.acc_out;
                z_reg   <= res_next.zero_flag;
                n_reg   <= res_next.subtract_flag;
                h_reg   <= res_next.half_flag;
                c_reg   <= res_next.carry_flag;
                ime_reg <= res_next.irq_enabled;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.result_byte   = res_reg.result_byte;
    assign out_ch.result_word   = res_reg.result_word;
    assign out_ch.acc_out       = res_reg.acc_out;
    assign out_ch.zero_flag     = res_reg.zero_flag;
    assign out_ch.subtract_flag = res_reg.subtract_flag;
    assign out_ch.half_flag     = res_reg.half_flag;
    assign out_ch.carry_flag    = res_reg.carry_flag;
    assign out_ch.irq_enabled   = res_reg.irq_enabled;

    a_acc_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_ch.acc_out == acc_reg && out_ch.carry_flag == c_reg)
        else $error("shown result disagrees with held state");
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(acc_reg) && $stable(ime_reg))
        else $error("state changed without an item");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(res_reg))
        else $error("stalled result lost");

endmodule

/* verif/c8alu_tb_if.sv */
`timescale 1ns / 100ps

// The design folder already defines the channel interfaces; this file keeps a small
// bundle of the word fields that the bench passes between its processes.
package c8alu_tb_pkg;

    typedef struct {
        logic [5:0]  op;
        logic [7:0]  operand_byte;
        logic        target_is_acc;
        logic [2:0]  bit_index;
        logic [15:0] word_left;
        logic [15:0] word_right;
        logic [7:0]  offset;
    } alu_word_t;
endpackage

/* verif/tb_cpu8_alu_with_flags_core.sv */
`timescale 1ns / 100ps

module tb_cpu8_alu_with_flags_core;

    localparam int HOLD_OFF_CYCLES = 40;

    logic clk;
    logic rst_n;

    c8alu_in_if  in_ch ();
    c8alu_out_if out_ch ();

    cpu8_alu_with_flags_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    c8alu_pkg::result_t expected_results[$];
    logic [7:0] acc_model;
    logic       z_model, n_model, h_model, c_model, ime_model;
    int         error_count = 0;
    bit         quiet_sender;
    bit         quiet_receiver;
    bit         hold_active = 1'b0;
    event       hold_off_ev;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("cpu8_alu_with_flags_core regression: fail");
        $finish;
    end

    function automatic logic [7:0] shift_byte(input logic [2:0] kind, input logic [7:0] v,
                                              input logic cin, output logic cout);
        logic [7:0] r;
        case (kind)
            3'd0: begin cout = v[7]; r = {v[6:0], v[7]}; end
            3'd1: begin cout = v[7]; r = {v[6:0], cin}; end
            3'd2: begin cout = v[0]; r = {v[0], v[7:1]}; end
            3'd3: begin cout = v[0]; r = {cin, v[7:1]}; end
            3'd4: begin cout = v[7]; r = {v[6:0], 1'b0}; end
            3'd5: begin cout = v[0]; r = {v[7], v[7:1]}; end
            3'd6: begin cout = v[0]; r = {1'b0, v[7:1]}; end
            default: begin cout = 1'b0; r = {v[3:0], v[7:4]}; end
        endcase
        return r;
    endfunction

    // Advances the accumulator, flags and interrupt enable by one word and
    // returns what the block must report for it.
    function automatic c8alu_pkg::result_t execute_op(input c8alu_tb_pkg::alu_word_t w);
        c8alu_pkg::result_t r;
        logic [7:0]  a, v, rb;
        logic [15:0] rw;
        logic [8:0]  sum9;
        logic [16:0] sum17;
        logic        z, n, h, c, cin, co;
        a = acc_model; v = w.operand_byte;
        z = z_model; n = n_model; h = h_model; c = c_model;
        rb = 8'd0; rw = 16'd0;
        case (w.op)
            c8alu_pkg::OP_ADD, c8alu_pkg::OP_ADC:
            begin
                cin = (w.op == c8alu_pkg::OP_ADC) ? c : 1'b0;
                sum9 = {1'b0, a} + {1'b0, v} + 9'(cin);
                h = ({1'b0, a[3:0]} + {1'b0, v[3:0]} + 5'(cin)) > 5'd15;
                c = sum9[8]; a = sum9[7:0]; z = (a == 8'd0); n = 1'b0; rb = a;
            end
            c8alu_pkg::OP_SUB, c8alu_pkg::OP_SBC, c8alu_pkg::OP_CP:
            begin
                cin = (w.op == c8alu_pkg::OP_SBC) ? c : 1'b0;
                h = {1'b0, a[3:0]} < ({1'b0, v[3:0]} + 5'(cin));
                c = {1'b0, a} < ({1'b0, v} + 9'(cin));
                rb = a - v - 8'(cin); z = (rb == 8'd0); n = 1'b1;
                if (w.op != c8alu_pkg::OP_CP) a = rb;
            end
            c8alu_pkg::OP_AND:
            begin
                a = a & v; z = (a == 8'd0); n = 1'b0; h = 1'b1; c = 1'b0; rb = a;
            end
            c8alu_pkg::OP_OR:
            begin
                a = a | v; z = (a == 8'd0); n = 1'b0; h = 1'b0; c = 1'b0; rb = a;
            end
            c8alu_pkg::OP_XOR:
            begin
                a = a ^ v; z = (a == 8'd0); n = 1'b0; h = 1'b0; c = 1'b0; rb = a;
            end
            c8alu_pkg::OP_INC8:
            begin
                rb = v + 8'd1; z = (rb == 8'd0); n = 1'b0; h = (v[3:0] == 4'hF);
                if (w.target_is_acc) a = rb;
            end
            c8alu_pkg::OP_DEC8:
            begin
                rb = v - 8'd1; z = (rb == 8'd0); n = 1'b1; h = (v[3:0] == 4'h0);
                if (w.target_is_acc) a = rb;
            end
            c8alu_pkg::OP_INC16: rw = w.word_left + 16'd1;
            c8alu_pkg::OP_DEC16: rw = w.word_left - 16'd1;
            c8alu_pkg::OP_CPL: begin a = ~a; n = 1'b1; h = 1'b1; rb = a; end
            c8alu_pkg::OP_BIT: begin z = ~v[w.bit_index]; n = 1'b0; h = 1'b1; rb = v; end
            c8alu_pkg::OP_RES:
            begin
                rb = v; rb[w.bit_index] = 1'b0;
                if (w.target_is_acc) a = rb;
            end
            c8alu_pkg::OP_SET:
            begin
                rb = v; rb[w.bit_index] = 1'b1;
                if (w.target_is_acc) a = rb;
            end
            c8alu_pkg::OP_RLCA, c8alu_pkg::OP_RLA, c8alu_pkg::OP_RRCA, c8alu_pkg::OP_RRA:
            begin
                a = shift_byte(3'(w.op - c8alu_pkg::OP_RLCA), a, c, co);
                c = co; z = 1'b0; n = 1'b0; h = 1'b0; rb = a;
            end
            c8alu_pkg::OP_RLC, c8alu_pkg::OP_RL, c8alu_pkg::OP_RRC, c8alu_pkg::OP_RR,
            c8alu_pkg::OP_SLA, c8alu_pkg::OP_SRA, c8alu_pkg::OP_SRL, c8alu_pkg::OP_SWAP:
            begin
                rb = shift_byte(3'(w.op - c8alu_pkg::OP_RLC), v, c, co);
                c = co; z = (rb == 8'd0); n = 1'b0; h = 1'b0;
                if (w.target_is_acc) a = rb;
            end
            c8alu_pkg::OP_CCF: begin c = ~c; n = 1'b0; h = 1'b0; end
            c8alu_pkg::OP_SCF: begin c = 1'b1; n = 1'b0; h = 1'b0; end
            c8alu_pkg::OP_ADDHL:
            begin
                sum17 = {1'b0, w.word_left} + {1'b0, w.word_right};
                h = ({1'b0, w.word_left[11:0]} + {1'b0, w.word_right[11:0]}) > 13'hFFF;
                c = sum17[16]; n = 1'b0; rw = sum17[15:0];
            end
            c8alu_pkg::OP_ADDSP:
            begin
                rw = w.word_left + {{8{w.offset[7]}}, w.offset};
                h = ({1'b0, w.word_left[3:0]} + {1'b0, w.offset[3:0]}) > 5'd15;
                sum9 = {1'b0, w.word_left[7:0]} + {1'b0, w.offset};
                c = sum9[8]; z = 1'b0; n = 1'b0;
            end
            c8alu_pkg::OP_DAA:
            begin
                if (!n)
                begin
                    if (c || a > 8'h99) begin a = a + 8'h60; c = 1'b1; end
                    if (h || a[3:0] > 4'h9) a = a + 8'h06;
                end
                else
                begin
                    if (c) a = a - 8'h60;
                    if (h) a = a - 8'h06;
                end
                z = (a == 8'd0); h = 1'b0; rb = a;
            end
            c8alu_pkg::OP_DI: ime_model = 1'b0;
            c8alu_pkg::OP_EI: ime_model = 1'b1;
            default: ;
        endcase
        acc_model = a; z_model = z; n_model = n; h_model = h; c_model = c;
        r.result_byte = rb; r.result_word = rw; r.acc_out = a;
        r.zero_flag = z; r.subtract_flag = n; r.half_flag = h; r.carry_flag = c;
        r.irq_enabled = ime_model;
        return r;
    endfunction

    // Valid stays high after an accepted word so that words can follow back to
    // back; it drops only for an idle gap or when the bench waits to drain.
    task automatic send_word(input c8alu_tb_pkg::alu_word_t w);
        logic gap;
        gap = !quiet_sender && ($urandom_range(0, 99) < 8);
        if (gap)
            in_ch.valid <= 1'b0;
        while (gap)
        begin
            @(posedge clk);
            gap = $urandom_range(0, 99) < 8;
        end
        in_ch.valid         <= 1'b1;
        in_ch.op            <= w.op;
        in_ch.operand_byte  <= w.operand_byte;
        in_ch.target_is_acc <= w.target_is_acc;
        in_ch.bit_index     <= w.bit_index;
        in_ch.word_left     <= w.word_left;
        in_ch.word_right    <= w.word_right;
        in_ch.offset        <= w.offset;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_results.push_back(execute_op(w));
    endtask

    function automatic c8alu_tb_pkg::alu_word_t random_word(input logic [5:0] op);
        c8alu_tb_pkg::alu_word_t w;
        w.op = op;
        w.operand_byte = 8'($urandom);
        w.target_is_acc = 1'($urandom);
        w.bit_index = 3'($urandom);
        w.word_left = 16'($urandom);
        w.word_right = 16'($urandom);
        w.offset = 8'($urandom);
        return w;
    endfunction

    // Counts out a long held-off stretch of the receiver on request.
    always @(hold_off_ev)
    begin
        hold_active <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Random source of ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_active)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= quiet_receiver || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge clk)
    begin
        c8alu_pkg::result_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.result_byte = out_ch.result_byte;
            got.result_word = out_ch.result_word;
            got.acc_out = out_ch.acc_out;
            got.zero_flag = out_ch.zero_flag;
            got.subtract_flag = out_ch.subtract_flag;
            got.half_flag = out_ch.half_flag;
            got.carry_flag = out_ch.carry_flag;
            got.irq_enabled = out_ch.irq_enabled;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    $display("%0t:   byte %h/%h word %h/%h acc %h/%h",
                             $time, want.result_byte, got.result_byte, want.result_word,
                             got.result_word, want.acc_out, got.acc_out);
                    $display("%0t:   znhc %b%b%b%b/%b%b%b%b ime %b/%b",
                             $time, want.zero_flag, want.subtract_flag, want.half_flag,
                             want.carry_flag, got.zero_flag, got.subtract_flag,
                             got.half_flag, got.carry_flag, want.irq_enabled,
                             got.irq_enabled);
                    error_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Every operation but AND, OR and XOR, and two unused codes, with the operand extremes and the
    // flag corner cases the ALU treats specially.
    task automatic test_directed();
        c8alu_tb_pkg::alu_word_t w;
        w = random_word(c8alu_pkg::OP_ADD); w.operand_byte = 8'hFF; send_word(w);
        w = random_word(c8alu_pkg::OP_ADC); w.operand_byte = 8'h01; send_word(w);
        w = random_word(c8alu_pkg::OP_SUB); w.operand_byte = 8'h00; send_word(w);
        w = random_word(c8alu_pkg::OP_SBC); w.operand_byte = 8'hFF; send_word(w);
        w = random_word(c8alu_pkg::OP_CP);  w.operand_byte = 8'h80; send_word(w);
        w = random_word(c8alu_pkg::OP_INC8); w.operand_byte = 8'hFF;
        w.target_is_acc = 1'b1; send_word(w);
        w = random_word(c8alu_pkg::OP_DEC8); w.operand_byte = 8'h00;
        w.target_is_acc = 1'b0; send_word(w);
        w = random_word(c8alu_pkg::OP_INC16); w.word_left = 16'hFFFF; send_word(w);
        w = random_word(c8alu_pkg::OP_DEC16); w.word_left = 16'h0000; send_word(w);
        w = random_word(c8alu_pkg::OP_ADDHL); w.word_left = 16'h0FFF;
        w.word_right = 16'hF001; send_word(w);
        w = random_word(c8alu_pkg::OP_ADDSP); w.word_left = 16'h00FF;
        w.offset = 8'h80; send_word(w);
        w = random_word(c8alu_pkg::OP_ADDSP); w.word_left = 16'hFFFF;
        w.offset = 8'h7F; send_word(w);
        w = random_word(c8alu_pkg::OP_BIT); w.operand_byte = 8'h00;
        w.bit_index = 3'd7; send_word(w);
        w = random_word(c8alu_pkg::OP_RES); w.operand_byte = 8'hFF;
        w.target_is_acc = 1'b1; send_word(w);
        w = random_word(c8alu_pkg::OP_SET); w.operand_byte = 8'h00;
        w.target_is_acc = 1'b1; send_word(w);
        for (int op = c8alu_pkg::OP_RLCA; op <= c8alu_pkg::OP_RRA; op++)
            send_word(random_word(6'(op)));
        for (int op = c8alu_pkg::OP_RLC; op <= c8alu_pkg::OP_SWAP; op++)
            send_word(random_word(6'(op)));
        send_word(random_word(c8alu_pkg::OP_CPL));
        send_word(random_word(c8alu_pkg::OP_CCF));
        send_word(random_word(c8alu_pkg::OP_SCF));
        w = random_word(c8alu_pkg::OP_ADD); w.operand_byte = 8'h99; send_word(w);
        send_word(random_word(c8alu_pkg::OP_DAA));
        send_word(random_word(c8alu_pkg::OP_EI));
        send_word(random_word(c8alu_pkg::OP_DI));
        send_word(random_word(6'd35));
        send_word(random_word(6'd63));
        wait_drained();
    endtask

    // BCD sequences: load A, add or subtract, then adjust.
    task automatic test_bcd(input int count);
        c8alu_tb_pkg::alu_word_t w;
        for (int i = 0; i < count; i++)
        begin
            w = random_word(c8alu_pkg::OP_AND); w.operand_byte = 8'h00; send_word(w);
            w = random_word(c8alu_pkg::OP_OR);
            w.operand_byte = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            send_word(w);
            w = random_word(6'($urandom_range(0, 3)));
            w.operand_byte = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            send_word(w);
            send_word(random_word(c8alu_pkg::OP_DAA));
        end
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            quiet_sender = (i >= count / 3) && (i < count / 2);
            quiet_receiver = quiet_sender;
            if ($urandom_range(0, 19) == 0)
                send_word(random_word(6'($urandom_range(35, 63))));
            else
                send_word(random_word(6'($urandom_range(0, 34))));
        end
        quiet_sender = 0;
        quiet_receiver = 0;
    endtask

    // Receiver stalls long enough that the pipeline fills and input backs up.
    task automatic test_backpressure();
        -> hold_off_ev;
        for (int i = 0; i < 20; i++)
            send_word(random_word(6'($urandom_range(0, 34))));
        wait_drained();
    endtask

    initial
    begin
        quiet_sender = 0;
        quiet_receiver = 0;
        acc_model = 0; z_model = 0; n_model = 0; h_model = 0; c_model = 0; ime_model = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = '0;
        in_ch.operand_byte = '0;
        in_ch.target_is_acc = 1'b0;
        in_ch.bit_index = '0;
        in_ch.word_left = '0;
        in_ch.word_right = '0;
        in_ch.offset = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_bcd(30);
        test_backpressure();
        test_random(680);

        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("cpu8_alu_with_flags_core regression: pass");
        else
            $display("cpu8_alu_with_flags_core regression: fail");
        $finish;
    end
endmodule

/* sim.f */
design/c8alu_pkg.sv
design/c8alu_if.sv
design/c8alu_front.sv
design/c8alu_queue.sv
design/c8alu_back.sv
design/cpu8_alu_with_flags_core.sv
verif/c8alu_tb_if.sv
verif/tb_cpu8_alu_with_flags_core.sv
